### sv/ats_pkg.sv
// ----------------------------------------------------------------------------
// ats_pkg: shared types and constants for the assembler token scanner
// Record kinds, scan modes, character codes and the record structure.
// ----------------------------------------------------------------------------
package ats_pkg;

  typedef enum logic [2:0] {
    KIND_TEXT    = 3'd0,
    KIND_EOL     = 3'd1,
    KIND_COLON   = 3'd2,
    KIND_INT     = 3'd3,
    KIND_IDENT   = 3'd4,
    KIND_STRING  = 3'd5,
    KIND_BADCHAR = 3'd6,
    KIND_UNTERM  = 3'd7
  } rec_kind_e;

  typedef enum logic [3:0] {
    MODE_IDLE   = 4'b0001,
    MODE_NUMBER = 4'b0010,
    MODE_IDENT  = 4'b0100,
    MODE_STRING = 4'b1000
  } scan_mode_e;

  localparam logic [7:0]  CHAR_NL    = 8'h0A;
  localparam logic [7:0]  CHAR_TAB   = 8'h09;
  localparam logic [7:0]  CHAR_VT    = 8'h0B;
  localparam logic [7:0]  CHAR_FF    = 8'h0C;
  localparam logic [7:0]  CHAR_CR    = 8'h0D;
  localparam logic [7:0]  CHAR_SPACE = 8'h20;
  localparam logic [7:0]  CHAR_QUOTE = 8'h22;
  localparam logic [7:0]  CHAR_DOT   = 8'h2E;
  localparam logic [7:0]  CHAR_COLON = 8'h3A;
  localparam logic [7:0]  CHAR_UNDER = 8'h5F;

  localparam logic [30:0] VALUE_MAX  = 31'h7FFF_FFFF;

  typedef struct packed {
    rec_kind_e   kind;
    logic [7:0]  ch;
    logic [15:0] line;
    logic [15:0] col;
    logic [8:0]  len;
    logic [30:0] val;
    logic        err;
    logic        last;
  } rec_t;

  function automatic rec_t mk_rec(rec_kind_e kind, logic [7:0] ch, logic [15:0] line,
                                  logic [15:0] col, logic [8:0] len, logic [30:0] val,
                                  logic err);
    rec_t r;
    r.kind = kind;
    r.ch   = ch;
    r.line = line;
    r.col  = col;
    r.len  = len;
    r.val  = val;
    r.err  = err;
    r.last = 1'b0;
    return r;
  endfunction

  function automatic logic is_digit(logic [7:0] b);
    return (b >= 8'h30) && (b <= 8'h39);
  endfunction

  function automatic logic is_ident(logic [7:0] b);
    return is_digit(b) || ((b >= 8'h61) && (b <= 8'h7A)) ||
           ((b >= 8'h41) && (b <= 8'h5A)) || (b == CHAR_DOT) || (b == CHAR_UNDER);
  endfunction

  function automatic logic is_blank(logic [7:0] b);
    return (b == CHAR_SPACE) || (b == CHAR_TAB) || (b == CHAR_VT) ||
           (b == CHAR_FF) || (b == CHAR_CR);
  endfunction

endpackage

### sv/assembler_token_scanner.sv
// ----------------------------------------------------------------------------
// assembler_token_scanner: streaming lexer for assembler source text
// One source byte per transfer in; eol, colon, integer, identifier, string,
// text-byte and error records out.
// ----------------------------------------------------------------------------
// The scanner takes one source byte per clock when not stalled; each record
// passes the input register and then the result register. A byte that closes
// an integer or identifier and also yields a record of its own makes two
// records; the second waits in a one-entry pending slot and the input is held
// until it moves to the output slot, so throughput is one byte per cycle
// except while a second record waits or the output stalls. tlast on the input
// marks end of text: the open token is closed (or reported unterminated) and
// all state, line and column included, returns to its reset value. Records
// carry tlast on the last record caused by a byte. Line and column saturate
// at all ones of POSITION_BITS and are reported in their low 16 bits; lengths
// saturate at MAX_TOKEN_LEN and integer values at 2^31-1.
module assembler_token_scanner #(
  parameter int MAX_TOKEN_LEN = 511,
  parameter int POSITION_BITS = 16
) (
  input  logic        clk_i,
  input  logic        rst_ni,
  input  logic        s_axis_tvalid,
  output logic        s_axis_tready,
  input  logic [7:0]  s_axis_tdata,   // source_byte
  input  logic        s_axis_tlast,   // end_of_input
  output logic        m_axis_tvalid,
  input  logic        m_axis_tready,
  // text_char[7:0], line_number[23:8], column_number[39:24], token_length[48:40],
  // integer_value[79:49], errors_seen[80], zero[87:81]
  output logic [87:0] m_axis_tdata,
  output logic [2:0]  m_axis_tuser,   // record_kind
  output logic        m_axis_tlast    // last_of_run
);

  localparam int LW = $clog2(MAX_TOKEN_LEN + 1);
  localparam int PB = POSITION_BITS;
  localparam logic [LW-1:0] LEN_MAX = LW'(MAX_TOKEN_LEN);
  localparam logic [PB-1:0] POS_MAX = {PB{1'b1}};
  localparam logic [PB-1:0] POS_ONE = PB'(1);

  // input register
  logic       in_valid_q;
  logic [7:0] byte_q;
  logic       eoi_q;

  // scanner state
  ats_pkg::scan_mode_e mode_q, mode_d;
  logic [PB-1:0] line_q, line_d, col_q, col_d;
  logic [PB-1:0] sline_q, sline_d, scol_q, scol_d;
  logic          first_q, first_d;
  logic [30:0]   acc_q, acc_d;
  logic [LW-1:0] len_q, len_d;
  logic          err_q, err_d;

  // result slots
  logic          out_valid_q, out_valid_d, pend_valid_q, pend_valid_d;
  ats_pkg::rec_t out_q, out_d, pend_q, pend_d;

  logic fire;

  // step datapath
  logic [PB-1:0] cl, cc;
  logic [LW-1:0] len_inc;
  logic [34:0]   acc_mul;
  logic [30:0]   acc_next;
  logic [PB+15:0] cl_w, cc_w, sl_w, sc_w;
  logic [LW+8:0]  lq_w, li_w;
  logic [15:0]   cl16, cc16, sl16, sc16;
  logic [8:0]    lq9, li9;

  logic                idle_v;
  ats_pkg::rec_t       idle_rec;
  ats_pkg::scan_mode_e idle_mode;
  logic                idle_start;
  logic [30:0]         idle_acc;
  logic [LW-1:0]       idle_len;
  logic                idle_err;

  logic          v0, v1;
  ats_pkg::rec_t rec0, rec1;

  assign fire          = in_valid_q && !pend_valid_q && (!out_valid_q || m_axis_tready);
  assign s_axis_tready = !in_valid_q || fire;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      in_valid_q <= 1'b0;
    end else if (s_axis_tready) begin
      in_valid_q <= s_axis_tvalid;
    end
  end

  always_ff @(posedge clk_i) begin
    if (s_axis_tvalid && s_axis_tready) begin
      byte_q <= s_axis_tdata;
      eoi_q  <= s_axis_tlast;
    end
  end

  // current position after this byte
  always_comb begin
    cl = line_q;
    cc = col_q;
    if (first_q) begin
      cl = line_q;
    end else if (byte_q == ats_pkg::CHAR_NL) begin
      cl = (line_q != POS_MAX) ? line_q + POS_ONE : line_q;
      cc = '0;
    end else begin
      cc = (col_q != POS_MAX) ? col_q + POS_ONE : col_q;
    end
  end

  assign len_inc  = (len_q < LEN_MAX) ? len_q + LW'(1) : len_q;
  assign acc_mul  = ({4'b0, acc_q} << 3) + ({4'b0, acc_q} << 1) + {31'b0, byte_q[3:0]};
  assign acc_next = (acc_mul > {4'b0, ats_pkg::VALUE_MAX}) ? ats_pkg::VALUE_MAX
                                                           : acc_mul[30:0];

  assign cl_w = {16'b0, cl};
  assign cc_w = {16'b0, cc};
  assign sl_w = {16'b0, sline_q};
  assign sc_w = {16'b0, scol_q};
  assign lq_w = {9'b0, len_q};
  assign li_w = {9'b0, len_inc};
  assign cl16 = cl_w[15:0];
  assign cc16 = cc_w[15:0];
  assign sl16 = sl_w[15:0];
  assign sc16 = sc_w[15:0];
  assign lq9  = lq_w[8:0];
  assign li9  = li_w[8:0];

  // idle-mode scan of the byte
  always_comb begin
    idle_v     = 1'b0;
    idle_rec   = ats_pkg::mk_rec(ats_pkg::KIND_EOL, 8'd0, cl16, cc16, 9'd0, 31'd0, err_q);
    idle_mode  = ats_pkg::MODE_IDLE;
    idle_start = 1'b0;
    idle_acc   = acc_q;
    idle_len   = len_q;
    idle_err   = err_q;
    if (byte_q == ats_pkg::CHAR_NL) begin
      idle_v = 1'b1;
    end else if (ats_pkg::is_blank(byte_q)) begin
      idle_v = 1'b0;
    end else if (byte_q == ats_pkg::CHAR_COLON) begin
      idle_v        = 1'b1;
      idle_rec.kind = ats_pkg::KIND_COLON;
    end else if (ats_pkg::is_digit(byte_q)) begin
      idle_mode  = ats_pkg::MODE_NUMBER;
      idle_start = 1'b1;
      idle_acc   = {27'b0, byte_q[3:0]};
      idle_len   = LW'(1);
    end else if (ats_pkg::is_ident(byte_q)) begin
      idle_mode  = ats_pkg::MODE_IDENT;
      idle_start = 1'b1;
      idle_acc   = '0;
      idle_len   = LW'(1);
      idle_v     = 1'b1;
      idle_rec   = ats_pkg::mk_rec(ats_pkg::KIND_TEXT, byte_q, cl16, cc16, 9'd1, 31'd0,
                                   err_q);
    end else if (byte_q == ats_pkg::CHAR_QUOTE) begin
      idle_mode  = ats_pkg::MODE_STRING;
      idle_start = 1'b1;
      idle_acc   = '0;
      idle_len   = '0;
    end else begin
      idle_err = 1'b1;
      idle_v   = 1'b1;
      idle_rec = ats_pkg::mk_rec(ats_pkg::KIND_BADCHAR, byte_q, cl16, cc16, 9'd0, 31'd0,
                                 1'b1);
    end
  end

  // one scan step
  always_comb begin
    mode_d  = mode_q;
    line_d  = line_q;
    col_d   = col_q;
    first_d = first_q;
    sline_d = sline_q;
    scol_d  = scol_q;
    acc_d   = acc_q;
    len_d   = len_q;
    err_d   = err_q;
    v0      = 1'b0;
    v1      = 1'b0;
    rec0    = ats_pkg::mk_rec(ats_pkg::KIND_INT, 8'd0, sl16, sc16, lq9, acc_q, err_q);
    rec1    = idle_rec;
    if (eoi_q) begin
      case (mode_q)
        ats_pkg::MODE_NUMBER: v0 = 1'b1;
        ats_pkg::MODE_IDENT: begin
          v0        = 1'b1;
          rec0.kind = ats_pkg::KIND_IDENT;
          rec0.val  = '0;
        end
        ats_pkg::MODE_STRING: begin
          v0        = 1'b1;
          rec0.kind = ats_pkg::KIND_UNTERM;
          rec0.val  = '0;
        end
        default: v0 = 1'b0;
      endcase
      mode_d  = ats_pkg::MODE_IDLE;
      line_d  = POS_ONE;
      col_d   = POS_ONE;
      first_d = 1'b1;
      sline_d = POS_ONE;
      scol_d  = POS_ONE;
      acc_d   = '0;
      len_d   = '0;
      err_d   = 1'b0;
    end else begin
      line_d  = cl;
      col_d   = cc;
      first_d = 1'b0;
      case (mode_q)
        ats_pkg::MODE_STRING: begin
          v0 = 1'b1;
          if (byte_q == ats_pkg::CHAR_QUOTE) begin
            rec0   = ats_pkg::mk_rec(ats_pkg::KIND_STRING, 8'd0, sl16, sc16, lq9, 31'd0,
                                     err_q);
            mode_d = ats_pkg::MODE_IDLE;
          end else begin
            len_d = len_inc;
            rec0  = ats_pkg::mk_rec(ats_pkg::KIND_TEXT, byte_q, sl16, sc16, li9, 31'd0,
                                    err_q);
          end
        end
        ats_pkg::MODE_NUMBER, ats_pkg::MODE_IDENT: begin
          if (mode_q == ats_pkg::MODE_NUMBER && ats_pkg::is_digit(byte_q)) begin
            acc_d = acc_next;
            len_d = len_inc;
          end else if (mode_q == ats_pkg::MODE_IDENT && ats_pkg::is_ident(byte_q)) begin
            len_d = len_inc;
            v0    = 1'b1;
            rec0  = ats_pkg::mk_rec(ats_pkg::KIND_TEXT, byte_q, sl16, sc16, li9, 31'd0,
                                    err_q);
          end else begin
            v0 = 1'b1;
            if (mode_q == ats_pkg::MODE_IDENT) begin
              rec0.kind = ats_pkg::KIND_IDENT;
              rec0.val  = '0;
            end
            v1     = idle_v;
            rec1   = idle_rec;
            mode_d = idle_mode;
            acc_d  = idle_acc;
            len_d  = idle_len;
            err_d  = idle_err;
            if (idle_start) begin
              sline_d = cl;
              scol_d  = cc;
            end
          end
        end
        default: begin
          v0     = idle_v;
          rec0   = idle_rec;
          mode_d = idle_mode;
          acc_d  = idle_acc;
          len_d  = idle_len;
          err_d  = idle_err;
          if (idle_start) begin
            sline_d = cl;
            scol_d  = cc;
          end
        end
      endcase
    end
    rec0.last = !v1;
    rec1.last = 1'b1;
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      mode_q  <= ats_pkg::MODE_IDLE;
      line_q  <= POS_ONE;
      col_q   <= POS_ONE;
      first_q <= 1'b1;
      sline_q <= POS_ONE;
      scol_q  <= POS_ONE;
      acc_q   <= '0;
      len_q   <= '0;
      err_q   <= 1'b0;
    end else if (fire) begin
      mode_q  <= mode_d;
      line_q  <= line_d;
      col_q   <= col_d;
      first_q <= first_d;
      sline_q <= sline_d;
      scol_q  <= scol_d;
      acc_q   <= acc_d;
      len_q   <= len_d;
      err_q   <= err_d;
    end
  end

  // result slot control
  always_comb begin
    out_valid_d  = out_valid_q;
    pend_valid_d = pend_valid_q;
    out_d        = out_q;
    pend_d       = pend_q;
    if (fire) begin
      out_valid_d  = v0;
      out_d        = rec0;
      pend_valid_d = v1;
      pend_d       = rec1;
    end else if (out_valid_q && m_axis_tready) begin
      out_valid_d  = pend_valid_q;
      out_d        = pend_q;
      pend_valid_d = 1'b0;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_valid_q  <= 1'b0;
      pend_valid_q <= 1'b0;
    end else begin
      out_valid_q  <= out_valid_d;
      pend_valid_q <= pend_valid_d;
    end
  end

  always_ff @(posedge clk_i) begin
    out_q  <= out_d;
    pend_q <= pend_d;
  end

  assign m_axis_tvalid = out_valid_q;
  assign m_axis_tuser  = out_q.kind;
  assign m_axis_tlast  = out_q.last;
  assign m_axis_tdata  = {7'b0, out_q.err, out_q.val, out_q.len, out_q.col, out_q.line,
                          out_q.ch};

`ifndef SYNTHESIS
  a_pend_needs_out: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> out_valid_q)
    else $error("pending record without a record in the output slot");

  a_pend_is_last: assert property (@(posedge clk_i) disable iff (!rst_ni)
    pend_valid_q |-> (pend_q.last && !out_q.last))
    else $error("last marking wrong on a two-record byte");

  a_err_sticky: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (err_q && !(fire && eoi_q)) |=> err_q)
    else $error("error flag cleared without end of input");

  a_no_fire_on_pend: assert property (@(posedge clk_i) disable iff (!rst_ni)
    (fire && v1) |=> (pend_valid_q && !fire))
    else $error("second record not held in pending slot");
`endif

endmodule

### tb/sv/testbench.sv
`timescale 1ns / 1ps
// ----------------------------------------------------------------------------
// testbench: assembler token scanner
// Feeds source text and end-of-text marks through the input stream and
// checks every record against a scanner model kept in the bench. A short
// table walks the corner cases (blank lines, saturated integers, token
// closed by a second record, bytes inside strings, end of text in idle,
// ident and string modes); then random assembler-like lines, noise and
// two overlong tokens, with bursty input and a receiver stalling at will.
// ----------------------------------------------------------------------------
module testbench;

  localparam int          RANDOM_ITEMS  = 1830;
  localparam int          IDLE_LIMIT    = 500;
  localparam int          DRAIN_CYCLES  = 16;
  localparam logic [15:0] POS_MAX       = 16'hFFFF;
  localparam logic [8:0]  TOKEN_LEN_MAX = 9'd511;

  typedef enum int {
    CC_OTHER, CC_DIGIT, CC_WORD, CC_BLANK, CC_NEWLINE, CC_COLON, CC_QUOTE
  } char_class_e;

  typedef struct packed {
    logic [7:0]         src;
    logic               eoi;
    logic               pinned;
    ats_pkg::rec_kind_e kind;
    logic [7:0]         ch;
    logic [15:0]        line;
    logic [15:0]        col;
  } stim_row_t;

  logic        clk_i = 1'b0;
  logic        rst_ni = 1'b0;
  logic        s_axis_tvalid = 1'b0;
  logic        s_axis_tready;
  logic [7:0]  s_axis_tdata = 8'h00;
  logic        s_axis_tlast = 1'b0;
  logic        m_axis_tvalid;
  logic        m_axis_tready = 1'b0;
  logic [87:0] m_axis_tdata;
  logic [2:0]  m_axis_tuser;
  logic        m_axis_tlast;

  char_class_e char_class [256];

  // scanner model state
  ats_pkg::scan_mode_e sc_mode;
  logic [15:0] sc_line, sc_col, tok_line, tok_col;
  logic        sc_fresh;
  logic [30:0] tok_value;
  logic [8:0]  tok_len;
  logic        sc_err;

  ats_pkg::rec_t step_recs[$];
  ats_pkg::rec_t records_due[$];
  logic [8:0]    feed_q[$];

  int fault_count = 0;
  int burst_left  = 0;
  int sink_tick   = 0;
  int sink_style  = 0;

  stim_row_t dir_rows [0:26] = '{
    '{8'h5A, 1'b1, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h0A, 1'b0, 1'b1, ats_pkg::KIND_EOL,     8'h00, 16'd1, 16'd1},
    '{8'h20, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h09, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h0A, 1'b0, 1'b1, ats_pkg::KIND_EOL,     8'h00, 16'd2, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h39, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h3A, 1'b0, 1'b1, ats_pkg::KIND_COLON,   8'h00, 16'd2, 16'd11},
    '{8'h41, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'hFF, 1'b0, 1'b1, ats_pkg::KIND_BADCHAR, 8'hFF, 16'd2, 16'd13},
    '{8'h22, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h00, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h0A, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h22, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h7A, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'hA5, 1'b1, 1'b1, ats_pkg::KIND_IDENT,   8'h00, 16'd3, 16'd2},
    '{8'h22, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h5F, 1'b0, 1'b0, ats_pkg::KIND_TEXT,    8'h00, 16'd0, 16'd0},
    '{8'h00, 1'b1, 1'b1, ats_pkg::KIND_UNTERM,  8'h00, 16'd1, 16'd1}
  };

  assembler_token_scanner dut (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .s_axis_tvalid(s_axis_tvalid),
    .s_axis_tready(s_axis_tready),
    .s_axis_tdata (s_axis_tdata),
    .s_axis_tlast (s_axis_tlast),
    .m_axis_tvalid(m_axis_tvalid),
    .m_axis_tready(m_axis_tready),
    .m_axis_tdata (m_axis_tdata),
    .m_axis_tuser (m_axis_tuser),
    .m_axis_tlast (m_axis_tlast)
  );

  initial begin
    forever #10 clk_i = ~clk_i;
  end

  // ---------------------------------------------------------------- model

  function automatic void scanner_clear();
    sc_mode   = ats_pkg::MODE_IDLE;
    sc_line   = 16'd1;
    sc_col    = 16'd1;
    sc_fresh  = 1'b1;
    tok_line  = 16'd1;
    tok_col   = 16'd1;
    tok_value = '0;
    tok_len   = '0;
    sc_err    = 1'b0;
  endfunction

  function automatic void add_rec(ats_pkg::rec_kind_e k, logic [7:0] c, logic [15:0] l,
                                  logic [15:0] cl, logic [8:0] n, logic [30:0] v);
    ats_pkg::rec_t r;
    r.kind = k;
    r.ch   = c;
    r.line = l;
    r.col  = cl;
    r.len  = n;
    r.val  = v;
    r.err  = sc_err;
    r.last = 1'b0;
    step_recs.push_back(r);
  endfunction

  function automatic void bump_len();
    if (tok_len != TOKEN_LEN_MAX) tok_len++;
  endfunction

  function automatic void open_token(ats_pkg::scan_mode_e m, logic [30:0] v, logic [8:0] n);
    sc_mode   = m;
    tok_line  = sc_line;
    tok_col   = sc_col;
    tok_value = v;
    tok_len   = n;
  endfunction

  function automatic void scan_from_idle(logic [7:0] b);
    case (char_class[b])
      CC_NEWLINE: add_rec(ats_pkg::KIND_EOL, 8'h00, sc_line, sc_col, 9'd0, 31'd0);
      CC_BLANK: ;
      CC_COLON: add_rec(ats_pkg::KIND_COLON, 8'h00, sc_line, sc_col, 9'd0, 31'd0);
      CC_DIGIT: open_token(ats_pkg::MODE_NUMBER, 31'(b - 8'h30), 9'd1);
      CC_WORD: begin
        open_token(ats_pkg::MODE_IDENT, 31'd0, 9'd1);
        add_rec(ats_pkg::KIND_TEXT, b, tok_line, tok_col, tok_len, 31'd0);
      end
      CC_QUOTE: open_token(ats_pkg::MODE_STRING, 31'd0, 9'd0);
      default: begin
        sc_err = 1'b1;
        add_rec(ats_pkg::KIND_BADCHAR, b, sc_line, sc_col, 9'd0, 31'd0);
      end
    endcase
  endfunction

  // Works out the records for one accepted transfer into step_recs.
  function automatic void scan_byte(logic [7:0] b, logic eoi);
    logic [34:0]   grown;
    ats_pkg::rec_t tail;
    step_recs.delete();
    if (eoi) begin
      case (sc_mode)
        ats_pkg::MODE_NUMBER:
          add_rec(ats_pkg::KIND_INT, 8'h00, tok_line, tok_col, tok_len, tok_value);
        ats_pkg::MODE_IDENT:
          add_rec(ats_pkg::KIND_IDENT, 8'h00, tok_line, tok_col, tok_len, 31'd0);
        ats_pkg::MODE_STRING:
          add_rec(ats_pkg::KIND_UNTERM, 8'h00, tok_line, tok_col, tok_len, 31'd0);
        default: ;
      endcase
      scanner_clear();
    end else begin
      if (sc_fresh) begin
        sc_fresh = 1'b0;
      end else if (b == ats_pkg::CHAR_NL) begin
        if (sc_line != POS_MAX) sc_line++;
        sc_col = 16'd0;
      end else if (sc_col != POS_MAX) begin
        sc_col++;
      end
      case (sc_mode)
        ats_pkg::MODE_STRING: begin
          if (b == ats_pkg::CHAR_QUOTE) begin
            add_rec(ats_pkg::KIND_STRING, 8'h00, tok_line, tok_col, tok_len, 31'd0);
            sc_mode = ats_pkg::MODE_IDLE;
          end else begin
            bump_len();
            add_rec(ats_pkg::KIND_TEXT, b, tok_line, tok_col, tok_len, 31'd0);
          end
        end
        ats_pkg::MODE_NUMBER: begin
          if (char_class[b] == CC_DIGIT) begin
            grown = 35'(tok_value) * 35'd10 + 35'(b - 8'h30);
            tok_value = (grown > 35'(ats_pkg::VALUE_MAX)) ? ats_pkg::VALUE_MAX
                                                          : grown[30:0];
            bump_len();
          end else begin
            add_rec(ats_pkg::KIND_INT, 8'h00, tok_line, tok_col, tok_len, tok_value);
            sc_mode = ats_pkg::MODE_IDLE;
            scan_from_idle(b);
          end
        end
        ats_pkg::MODE_IDENT: begin
          if (char_class[b] == CC_DIGIT || char_class[b] == CC_WORD) begin
            bump_len();
            add_rec(ats_pkg::KIND_TEXT, b, tok_line, tok_col, tok_len, 31'd0);
          end else begin
            add_rec(ats_pkg::KIND_IDENT, 8'h00, tok_line, tok_col, tok_len, 31'd0);
            sc_mode = ats_pkg::MODE_IDLE;
            scan_from_idle(b);
          end
        end
        default: scan_from_idle(b);
      endcase
    end
    if (step_recs.size() > 0) begin
      tail = step_recs.pop_back();
      tail.last = 1'b1;
      step_recs.push_back(tail);
    end
  endfunction

  // ---------------------------------------------------------------- source text

  function automatic void put(logic [7:0] b);
    feed_q.push_back({1'b0, b});
  endfunction

  function automatic void put_end();
    feed_q.push_back({1'b1, 8'($urandom_range(0, 255))});
  endfunction

  function automatic logic [7:0] word_byte(logic lead);
    int r;
    r = lead ? $urandom_range(0, 53) : $urandom_range(0, 63);
    if (r < 26) return 8'h61 + 8'(r);
    if (r < 52) return 8'h41 + 8'(r - 26);
    if (r == 52) return ats_pkg::CHAR_DOT;
    if (r == 53) return ats_pkg::CHAR_UNDER;
    return 8'h30 + 8'(r - 54);
  endfunction

  function automatic void put_ident(int n);
    put(word_byte(1'b1));
    for (int i = 1; i < n; i++) put(word_byte(1'b0));
  endfunction

  function automatic void put_number();
    int n;
    n = ($urandom_range(0, 9) == 0) ? $urandom_range(10, 13) : $urandom_range(1, 4);
    for (int i = 0; i < n; i++) put(8'($urandom_range(8'h30, 8'h39)));
  endfunction

  function automatic void put_string(int n);
    logic [7:0] b;
    put(ats_pkg::CHAR_QUOTE);
    for (int i = 0; i < n; i++) begin
      if ($urandom_range(0, 6) != 0) b = 8'($urandom_range(8'h20, 8'h7E));
      else b = 8'($urandom_range(0, 255));
      if (b == ats_pkg::CHAR_QUOTE) b = ats_pkg::CHAR_UNDER;
      put(b);
    end
    if ($urandom_range(0, 15) == 0) put_end();
    else put(ats_pkg::CHAR_QUOTE);
  endfunction

  function automatic void put_blanks();
    int n;
    n = $urandom_range(0, 2);
    for (int i = 0; i < n; i++) begin
      case ($urandom_range(0, 7))
        0: put(ats_pkg::CHAR_TAB);
        1: put(ats_pkg::CHAR_VT);
        2: put(ats_pkg::CHAR_FF);
        3: put(ats_pkg::CHAR_CR);
        default: put(ats_pkg::CHAR_SPACE);
      endcase
    end
  endfunction

  function automatic void build_line();
    int ops;
    if ($urandom_range(0, 11) == 0) begin
      ops = $urandom_range(1, 6);
      for (int i = 0; i < ops; i++) put(8'($urandom_range(0, 255)));
      put(ats_pkg::CHAR_NL);
      return;
    end
    if ($urandom_range(0, 3) == 0) begin
      put_ident($urandom_range(1, 8));
      put(ats_pkg::CHAR_COLON);
    end
    put_blanks();
    if ($urandom_range(0, 7) != 0) begin
      put_ident($urandom_range(2, 6));
      ops = $urandom_range(0, 3);
      for (int i = 0; i < ops; i++) begin
        case ($urandom_range(0, 6))
          0: put(8'h2C);
          1: put(ats_pkg::CHAR_COLON);
          default: put_blanks();
        endcase
        case ($urandom_range(0, 9))
          0, 1, 2, 3: put_number();
          4, 5, 6: put_ident($urandom_range(1, 7));
          default: put_string($urandom_range(0, 8));
        endcase
      end
    end
    if ($urandom_range(0, 9) == 0) put(8'($urandom_range(0, 255)));
    put_blanks();
    if ($urandom_range(0, 24) == 0) begin
      put_end();
    end else begin
      if ($urandom_range(0, 5) == 0) put(ats_pkg::CHAR_CR);
      put(ats_pkg::CHAR_NL);
    end
  endfunction

  // ---------------------------------------------------------------- drivers

  // Handshake is judged at the falling edge, where both sides are stable.
  task automatic push_transfer(logic [7:0] b, logic eoi);
    logic taken;
    s_axis_tvalid <= 1'b1;
    s_axis_tdata  <= b;
    s_axis_tlast  <= eoi;
    do begin
      @(negedge clk_i);
      taken = s_axis_tready;
      if (taken) begin
        scan_byte(b, eoi);
        foreach (step_recs[i]) records_due.push_back(step_recs[i]);
      end
      @(posedge clk_i);
    end while (!taken);
  endtask

  task automatic send_item(logic [7:0] b, logic eoi);
    int gap;
    if (burst_left == 0) begin
      burst_left = $urandom_range(1, 48);
      gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 9);
      if (gap > 0) begin
        s_axis_tvalid <= 1'b0;
        repeat (gap) @(posedge clk_i);
      end
    end
    burst_left--;
    push_transfer(b, eoi);
  endtask

  task automatic hold_until_drained();
    s_axis_tvalid <= 1'b0;
    do @(posedge clk_i); while (records_due.size() != 0);
    burst_left = 0;
  endtask

  always @(posedge clk_i) begin
    sink_tick++;
    if (sink_tick % 200 == 0) sink_style = $urandom_range(0, 3);
    case (sink_style)
      0: m_axis_tready <= 1'b1;
      1: m_axis_tready <= ~m_axis_tready;
      2: m_axis_tready <= ($urandom_range(0, 3) != 0);
      default: m_axis_tready <= ((sink_tick % 16) >= 10);
    endcase
  end

  // ---------------------------------------------------------------- checking

  function automatic void cmp_field(string name, logic [31:0] want, logic [31:0] got);
    if (want !== got) begin
      fault_count++;
      $error("%s: expected %0d, got %0d", name, want, got);
    end
  endfunction

  always @(negedge clk_i) begin : record_check
    ats_pkg::rec_t want;
    if (rst_ni && m_axis_tvalid && m_axis_tready) begin
      if (records_due.size() == 0) begin
        fault_count++;
        $error("record with nothing due: kind %0d data %h", m_axis_tuser, m_axis_tdata);
      end else begin
        want = records_due.pop_front();
        cmp_field("record_kind", 32'(want.kind), 32'(m_axis_tuser));
        cmp_field("text_char", 32'(want.ch), 32'(m_axis_tdata[7:0]));
        cmp_field("line_number", 32'(want.line), 32'(m_axis_tdata[23:8]));
        cmp_field("column_number", 32'(want.col), 32'(m_axis_tdata[39:24]));
        cmp_field("token_length", 32'(want.len), 32'(m_axis_tdata[48:40]));
        cmp_field("integer_value", 32'(want.val), 32'(m_axis_tdata[79:49]));
        cmp_field("errors_seen", 32'(want.err), 32'(m_axis_tdata[80]));
        cmp_field("last_of_run", 32'(want.last), 32'(m_axis_tlast));
      end
    end
  end

  initial begin : watchdog
    int idle_cycles;
    idle_cycles = 0;
    while (idle_cycles < IDLE_LIMIT) begin
      @(negedge clk_i);
      if (!rst_ni || (s_axis_tvalid && s_axis_tready) || (m_axis_tvalid && m_axis_tready))
        idle_cycles = 0;
      else
        idle_cycles++;
    end
    $display("testbench: done, errors");
    $finish;
  end

  // ---------------------------------------------------------------- sequence

  initial begin : stimulus
    int         sent;
    logic [8:0] item;
    logic       drained, long_word_done, long_str_done;
    sent           = 0;
    drained        = 1'b0;
    long_word_done = 1'b0;
    long_str_done  = 1'b0;

    for (int c = 0; c < 256; c++) char_class[c] = CC_OTHER;
    for (int c = 8'h30; c <= 8'h39; c++) char_class[c] = CC_DIGIT;
    for (int c = 8'h41; c <= 8'h5A; c++) char_class[c] = CC_WORD;
    for (int c = 8'h61; c <= 8'h7A; c++) char_class[c] = CC_WORD;
    char_class[ats_pkg::CHAR_DOT]   = CC_WORD;
    char_class[ats_pkg::CHAR_UNDER] = CC_WORD;
    char_class[ats_pkg::CHAR_SPACE] = CC_BLANK;
    char_class[ats_pkg::CHAR_TAB]   = CC_BLANK;
    char_class[ats_pkg::CHAR_VT]    = CC_BLANK;
    char_class[ats_pkg::CHAR_FF]    = CC_BLANK;
    char_class[ats_pkg::CHAR_CR]    = CC_BLANK;
    char_class[ats_pkg::CHAR_NL]    = CC_NEWLINE;
    char_class[ats_pkg::CHAR_COLON] = CC_COLON;
    char_class[ats_pkg::CHAR_QUOTE] = CC_QUOTE;
    scanner_clear();

    repeat (11) @(posedge clk_i);
    rst_ni <= 1'b1;
    @(posedge clk_i);

    foreach (dir_rows[i]) begin
      send_item(dir_rows[i].src, dir_rows[i].eoi);
      if (dir_rows[i].pinned) begin
        if (step_recs.size() == 0 || step_recs[$].kind != dir_rows[i].kind ||
            step_recs[$].ch != dir_rows[i].ch || step_recs[$].line != dir_rows[i].line ||
            step_recs[$].col != dir_rows[i].col) begin
          fault_count++;
          $error("row %0d: model gives kind %0d at %0d:%0d, table says kind %0d at %0d:%0d",
                 i, step_recs[$].kind, step_recs[$].line, step_recs[$].col,
                 dir_rows[i].kind, dir_rows[i].line, dir_rows[i].col);
        end
      end
    end

    while (sent < RANDOM_ITEMS) begin
      if (feed_q.size() == 0) begin
        if (!long_word_done && sent > 300) begin
          long_word_done = 1'b1;
          put_ident(514);
          put(ats_pkg::CHAR_NL);
        end else if (!long_str_done && sent > 1000) begin
          long_str_done = 1'b1;
          put_string(514);
          put(ats_pkg::CHAR_NL);
        end else begin
          build_line();
        end
      end
      item = feed_q.pop_front();
      send_item(item[7:0], item[8]);
      sent++;
      if (!drained && sent > RANDOM_ITEMS / 2) begin
        drained = 1'b1;
        hold_until_drained();
      end
    end

    hold_until_drained();
    repeat (DRAIN_CYCLES) @(posedge clk_i);
    if (fault_count == 0)
      $display("testbench: done, clean");
    else
      $display("testbench: done, errors");
    $finish;
  end

endmodule
